/* hw/rtl/qau_pkg.sv */
package qau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE = WORD_BITS + FRAC_BITS + 2;
  localparam int QUO_BITS = WORD_BITS + FRAC_BITS;
  localparam int DIV_CELLS = QUO_BITS;
  localparam int SQRT_CELLS = WORD_BITS + 1;
  localparam int ROOT_BITS = SQRT_CELLS;
  localparam int SQ_BITS = 2 * SQRT_CELLS;
  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int NPROD = 16;

  localparam logic [2:0] ACT_MUL  = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SCL  = 3'd2;
  localparam logic [2:0] ACT_DIV  = 3'd3;
  localparam logic [2:0] ACT_CONJ = 3'd4;
  localparam logic [2:0] ACT_NORM = 3'd5;
  localparam logic [2:0] ACT_ROWS = 3'd6;
  localparam logic [2:0] ACT_NOP  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic signed [WIDE-1:0] W_MAX = WIDE'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE-1:0] W_MIN = -W_MAX - WIDE'(1);
  localparam logic signed [WIDE-1:0] ONE = WIDE'(64'sd1 <<< FRAC_BITS);

  typedef struct packed {
    logic [2:0] action;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] factor;
  } qau_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic [1:0] status;
    logic last;
  } qau_out_t;

  typedef struct packed {
    logic valid;
    logic [2:0] act;
    logic [2:0][3:0][WIDE-1:0] rows;
    logic [SQ_BITS-1:0] sq;
    logic [ROOT_BITS-1:0] root;
    logic [REM_BITS-1:0] srem;
    logic [3:0] neg;
    logic [3:0][QUO_BITS-1:0] quo;
    logic [3:0][ROOT_BITS-1:0] drem;
    logic [ROOT_BITS-1:0] dvs;
  } qau_stage_t;

  function automatic logic [WIDE-1:0] sx_word(input logic signed [WORD_BITS-1:0] v);
    return {{(WIDE - WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  function automatic logic [WORD_BITS-1:0] abs_word(input logic signed [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // top bit flags saturation
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [WIDE-1:0] v);
    logic [WORD_BITS:0] r;
    if (v > W_MAX) begin
      r = {1'b1, W_MAX[WORD_BITS-1:0]};
    end else if (v < W_MIN) begin
      r = {1'b1, W_MIN[WORD_BITS-1:0]};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/qau_prod.sv */
module qau_prod import qau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  qau_in_t    req,
  output qau_stage_t st
);

  logic signed [31:0] opx [NPROD];
  logic signed [31:0] opy [NPROD];
  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [63:0] p [NPROD];
  logic v1;
  qau_in_t in1;
  logic signed [WIDE-1:0] sh [NPROD];
  logic signed [31:0] a1 [4];
  logic signed [31:0] b1 [4];
  logic [SQ_BITS-1:0] sqsum;
  qau_stage_t nx;

  assign av = '{req.a_x, req.a_y, req.a_z, req.a_w};
  assign bv = '{req.b_x, req.b_y, req.b_z, req.b_w};

  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      opx[k] = '0;
      opy[k] = '0;
    end
    unique case (req.action)
      ACT_MUL: begin
        opx[0] = av[3];  opy[0] = bv[3];
        opx[1] = av[0];  opy[1] = bv[0];
        opx[2] = av[1];  opy[2] = bv[1];
        opx[3] = av[2];  opy[3] = bv[2];
        opx[4] = av[3];  opy[4] = bv[0];
        opx[5] = av[0];  opy[5] = bv[3];
        opx[6] = av[1];  opy[6] = bv[2];
        opx[7] = av[2];  opy[7] = bv[1];
        opx[8] = av[3];  opy[8] = bv[1];
        opx[9] = av[1];  opy[9] = bv[3];
        opx[10] = av[2]; opy[10] = bv[0];
        opx[11] = av[0]; opy[11] = bv[2];
        opx[12] = av[3]; opy[12] = bv[2];
        opx[13] = av[2]; opy[13] = bv[3];
        opx[14] = av[0]; opy[14] = bv[1];
        opx[15] = av[1]; opy[15] = bv[0];
      end
      ACT_SCL: begin
        for (int j = 0; j < 4; j++) begin
          opx[j] = av[j];
          opy[j] = req.factor;
        end
      end
      ACT_NORM: begin
        for (int j = 0; j < 4; j++) begin
          opx[j] = av[j];
          opy[j] = av[j];
        end
      end
      ACT_ROWS: begin
        opx[0] = av[0]; opy[0] = av[0];
        opx[1] = av[1]; opy[1] = av[1];
        opx[2] = av[2]; opy[2] = av[2];
        opx[3] = av[0]; opy[3] = av[1];
        opx[4] = av[0]; opy[4] = av[2];
        opx[5] = av[1]; opy[5] = av[2];
        opx[6] = av[0]; opy[6] = av[3];
        opx[7] = av[1]; opy[7] = av[3];
        opx[8] = av[2]; opy[8] = av[3];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take && (req.action != ACT_NOP);
    end
    in1 <= req;
    for (int k = 0; k < NPROD; k++) begin
      p[k] <= opx[k] * opy[k];
    end
  end

  assign a1 = '{in1.a_x, in1.a_y, in1.a_z, in1.a_w};
  assign b1 = '{in1.b_x, in1.b_y, in1.b_z, in1.b_w};

  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      sh[k] = WIDE'(p[k] >>> FRAC_BITS);
    end
    sqsum = {2'b00, p[0]} + {2'b00, p[1]} + {2'b00, p[2]} + {2'b00, p[3]};
    nx = '0;
    nx.valid = v1;
    nx.act = in1.action;
    unique case (in1.action)
      ACT_MUL: begin
        nx.rows[0][3] = sh[0] - sh[1] - sh[2] - sh[3];
        nx.rows[0][0] = sh[4] + sh[5] + sh[6] - sh[7];
        nx.rows[0][1] = sh[8] + sh[9] + sh[10] - sh[11];
        nx.rows[0][2] = sh[12] + sh[13] + sh[14] - sh[15];
      end
      ACT_ADD: begin
        for (int j = 0; j < 4; j++) begin
          nx.rows[0][j] = sx_word(a1[j]) + sx_word(b1[j]);
        end
      end
      ACT_SCL: begin
        for (int j = 0; j < 4; j++) begin
          nx.rows[0][j] = sh[j];
        end
      end
      ACT_CONJ: begin
        for (int j = 0; j < 3; j++) begin
          nx.rows[0][j] = -sx_word(a1[j]);
        end
        nx.rows[0][3] = sx_word(a1[3]);
      end
      ACT_ROWS: begin
        nx.rows[0][0] = ONE - 2 * sh[1] - 2 * sh[2];
        nx.rows[0][1] = 2 * sh[3] - 2 * sh[8];
        nx.rows[0][2] = 2 * sh[4] + 2 * sh[7];
        nx.rows[1][0] = 2 * sh[3] + 2 * sh[8];
        nx.rows[1][1] = ONE - 2 * sh[0] - 2 * sh[2];
        nx.rows[1][2] = 2 * sh[5] - 2 * sh[6];
        nx.rows[2][0] = 2 * sh[4] - 2 * sh[7];
        nx.rows[2][1] = 2 * sh[5] + 2 * sh[6];
        nx.rows[2][2] = ONE - 2 * sh[0] - 2 * sh[1];
      end
      default: begin
      end
    endcase
    nx.sq = sqsum;
    for (int j = 0; j < 4; j++) begin
      nx.neg[j] = a1[j][WORD_BITS-1] ^ ((in1.action == ACT_DIV) && in1.factor[WORD_BITS-1]);
      nx.quo[j] = {abs_word(a1[j]), {FRAC_BITS{1'b0}}};
    end
    nx.dvs = ROOT_BITS'(abs_word(in1.factor));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= nx;
    end
  end

endmodule

/* hw/rtl/qau_sqrt_cell.sv */
module qau_sqrt_cell import qau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  qau_stage_t i,
  output qau_stage_t o
);

  logic [REM_BITS+1:0] t;
  logic [REM_BITS+1:0] trial;
  qau_stage_t nx;

  always_comb begin
    nx = i;
    t = {i.srem, i.sq[SQ_BITS-1:SQ_BITS-2]};
    trial = (REM_BITS + 2)'({i.root, 2'b01});
    nx.sq = {i.sq[SQ_BITS-3:0], 2'b00};
    if (t >= trial) begin
      nx.srem = REM_BITS'(t - trial);
      nx.root = {i.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      nx.srem = t[REM_BITS-1:0];
      nx.root = {i.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o <= '0;
    end else begin
      o <= nx;
    end
  end

endmodule

/* hw/rtl/qau_div_cell.sv */
module qau_div_cell import qau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  qau_stage_t i,
  output qau_stage_t o
);

  logic [ROOT_BITS:0] t [4];
  logic ge [4];
  qau_stage_t nx;

  always_comb begin
    nx = i;
    for (int j = 0; j < 4; j++) begin
      t[j] = {i.drem[j], i.quo[j][QUO_BITS-1]};
      ge[j] = t[j] >= {1'b0, i.dvs};
      nx.drem[j] = ge[j] ? ROOT_BITS'(t[j] - {1'b0, i.dvs}) : t[j][ROOT_BITS-1:0];
      nx.quo[j] = {i.quo[j][QUO_BITS-2:0], ge[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o <= '0;
    end else begin
      o <= nx;
    end
  end

endmodule

/* hw/rtl/quaternion_arithmetic_unit.sv */
// Fixed-point quaternion unit, one item per clock while busy is low. An item is taken when
// start is high and busy is low; its results leave on rsp, each marked by done for one cycle.
// Each item passes through the chain behind the multiplier stages: 33 square-root cells, one
// per root bit, then 48 divider cells, one per quotient bit. A matrix-rows item gives three
// results on consecutive cycles and holds busy high after it is taken; every other item
// gives one result and leaves busy low. Action 7 is taken and gives no result. The receiver
// cannot stall.
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  qau_in_t  req,
  output logic     done,
  output qau_out_t rsp
);

  qau_stage_t sq_chain [SQRT_CELLS+1];
  qau_stage_t dv_chain [DIV_CELLS+1];
  qau_stage_t e;
  logic [1:0] busy_cnt;
  logic [1:0] hold_cnt;
  logic [2:0][3:0][WIDE-1:0] hold;
  logic take;
  logic emit;
  logic zero;
  logic lastb;
  logic [3:0][WIDE-1:0] cur;
  logic [WORD_BITS:0] sv [4];
  logic [WIDE-1:0] qv;
  qau_out_t rsp_next;

  assign take = start && !busy;
  assign busy = busy_cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= 2'd0;
    end else if (take && (req.action == ACT_ROWS)) begin
      busy_cnt <= 2'd2;
    end else if (busy_cnt != 2'd0) begin
      busy_cnt <= busy_cnt - 2'd1;
    end
  end

  qau_prod u_prod (.clk(clk), .rst(rst), .take(take), .req(req), .st(sq_chain[0]));

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    qau_sqrt_cell u_cell (.clk(clk), .rst(rst), .i(sq_chain[g]), .o(sq_chain[g+1]));
  end

  // normalize divides by the root
  always_comb begin
    dv_chain[0] = sq_chain[SQRT_CELLS];
    if (sq_chain[SQRT_CELLS].act == ACT_NORM) begin
      dv_chain[0].dvs = sq_chain[SQRT_CELLS].root;
    end
  end

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    qau_div_cell u_cell (.clk(clk), .rst(rst), .i(dv_chain[g]), .o(dv_chain[g+1]));
  end

  assign e = dv_chain[DIV_CELLS];

  always_comb begin
    cur = e.rows[0];
    zero = 1'b0;
    lastb = e.act != ACT_ROWS;
    emit = e.valid;
    qv = '0;
    if (hold_cnt == 2'd2) begin
      cur = hold[1];
      lastb = 1'b0;
      emit = 1'b1;
    end else if (hold_cnt == 2'd1) begin
      cur = hold[2];
      lastb = 1'b1;
      emit = 1'b1;
    end else if ((e.act == ACT_DIV) || (e.act == ACT_NORM)) begin
      zero = e.dvs == '0;
      for (int j = 0; j < 4; j++) begin
        qv = {{(WIDE - QUO_BITS){1'b0}}, e.quo[j]};
        cur[j] = e.neg[j] ? -qv : qv;
      end
    end
    for (int j = 0; j < 4; j++) begin
      sv[j] = sat_word(cur[j]);
    end
    rsp_next.r_x = zero ? '0 : sv[0][WORD_BITS-1:0];
    rsp_next.r_y = zero ? '0 : sv[1][WORD_BITS-1:0];
    rsp_next.r_z = zero ? '0 : sv[2][WORD_BITS-1:0];
    rsp_next.r_w = zero ? '0 : sv[3][WORD_BITS-1:0];
    if (zero) begin
      rsp_next.status = ST_ZERO;
    end else if (sv[0][WORD_BITS] || sv[1][WORD_BITS] || sv[2][WORD_BITS]
                 || sv[3][WORD_BITS]) begin
      rsp_next.status = ST_SAT;
    end else begin
      rsp_next.status = ST_OK;
    end
    rsp_next.last = lastb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hold_cnt <= 2'd0;
    end else begin
      done <= emit;
      if (hold_cnt != 2'd0) begin
        hold_cnt <= hold_cnt - 2'd1;
      end else if (e.valid && (e.act == ACT_ROWS)) begin
        hold_cnt <= 2'd2;
      end
    end
    rsp <= rsp_next;
    if ((hold_cnt == 2'd0) && e.valid && (e.act == ACT_ROWS)) begin
      hold <= e.rows;
    end
  end

  a_rows_busy: assert property (@(posedge clk) disable iff (rst)
    take && (req.action == ACT_ROWS) |=> busy ##1 busy)
    else $error("matrix item did not block two cycles");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (hold_cnt != 2'd0) |-> !e.valid)
    else $error("item reached output while rows pending");

  a_row_follow: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |=> done)
    else $error("matrix row not followed by next row");

endmodule

/* tb/sv/quaternion_arithmetic_unit_checker.sv */
`timescale 1ns / 100ps

module quaternion_arithmetic_unit_checker import qau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  qau_in_t  req,
  input  logic     done,
  input  qau_out_t rsp,
  output int       errors,
  output int       pending
);

  qau_out_t exp_q[$];

  function automatic longint fl_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic qau_out_t pack_res(longint v0, longint v1, longint v2, longint v3,
                                        logic [1:0] st, logic lst);
    qau_out_t o;
    longint v[4];
    longint mx, mn;
    logic [1:0] s;
    v[0] = v0; v[1] = v1; v[2] = v2; v[3] = v3;
    mx = (64'sd1 <<< (WORD_BITS - 1)) - 1;
    mn = -mx - 1;
    s = st;
    for (int j = 0; j < 4; j++) begin
      if (v[j] > mx) begin
        v[j] = mx; s = ST_SAT;
      end else if (v[j] < mn) begin
        v[j] = mn; s = ST_SAT;
      end
    end
    if (st == ST_ZERO) s = ST_ZERO;
    o.r_x = v[0][31:0];
    o.r_y = v[1][31:0];
    o.r_z = v[2][31:0];
    o.r_w = v[3][31:0];
    o.status = s;
    o.last = lst;
    return o;
  endfunction

  function automatic longint root_floor(logic [64:0] s);
    logic [64:0] r, b;
    r = 0;
    b = 65'd1 << 64;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic predict_item(qau_in_t it);
    longint a[4], b[4], f, one, n;
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
    logic [64:0] sum;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z; a[3] = it.a_w;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z; b[3] = it.b_w;
    f = it.factor;
    one = 64'sd1 <<< FRAC_BITS;
    case (it.action)
      ACT_MUL: exp_q.push_back(pack_res(
        fl_mul(a[3], b[0]) + fl_mul(a[0], b[3]) + fl_mul(a[1], b[2]) - fl_mul(a[2], b[1]),
        fl_mul(a[3], b[1]) + fl_mul(a[1], b[3]) + fl_mul(a[2], b[0]) - fl_mul(a[0], b[2]),
        fl_mul(a[3], b[2]) + fl_mul(a[2], b[3]) + fl_mul(a[0], b[1]) - fl_mul(a[1], b[0]),
        fl_mul(a[3], b[3]) - fl_mul(a[0], b[0]) - fl_mul(a[1], b[1]) - fl_mul(a[2], b[2]),
        ST_OK, 1'b1));
      ACT_ADD: exp_q.push_back(pack_res(a[0] + b[0], a[1] + b[1], a[2] + b[2], a[3] + b[3],
                                        ST_OK, 1'b1));
      ACT_SCL: exp_q.push_back(pack_res(fl_mul(a[0], f), fl_mul(a[1], f), fl_mul(a[2], f),
                                        fl_mul(a[3], f), ST_OK, 1'b1));
      ACT_DIV: begin
        if (f == 0) exp_q.push_back(pack_res(0, 0, 0, 0, ST_ZERO, 1'b1));
        else exp_q.push_back(pack_res((a[0] * one) / f, (a[1] * one) / f, (a[2] * one) / f,
                                      (a[3] * one) / f, ST_OK, 1'b1));
      end
      ACT_CONJ: exp_q.push_back(pack_res(-a[0], -a[1], -a[2], a[3], ST_OK, 1'b1));
      ACT_NORM: begin
        sum = 0;
        for (int j = 0; j < 4; j++) sum = sum + 65'(a[j] * a[j]);
        n = sum[64] ? (64'sd1 <<< 32) : root_floor(sum);
        if (n == 0) exp_q.push_back(pack_res(0, 0, 0, 0, ST_ZERO, 1'b1));
        else exp_q.push_back(pack_res((a[0] * one) / n, (a[1] * one) / n, (a[2] * one) / n,
                                      (a[3] * one) / n, ST_OK, 1'b1));
      end
      ACT_ROWS: begin
        xx = fl_mul(a[0], a[0]); yy = fl_mul(a[1], a[1]); zz = fl_mul(a[2], a[2]);
        xy = fl_mul(a[0], a[1]); xz = fl_mul(a[0], a[2]); yz = fl_mul(a[1], a[2]);
        xw = fl_mul(a[0], a[3]); yw = fl_mul(a[1], a[3]); zw = fl_mul(a[2], a[3]);
        exp_q.push_back(pack_res(one - 2 * yy - 2 * zz, 2 * xy - 2 * zw, 2 * xz + 2 * yw, 0,
                                 ST_OK, 1'b0));
        exp_q.push_back(pack_res(2 * xy + 2 * zw, one - 2 * xx - 2 * zz, 2 * yz - 2 * xw, 0,
                                 ST_OK, 1'b0));
        exp_q.push_back(pack_res(2 * xz - 2 * yw, 2 * yz + 2 * xw, one - 2 * xx - 2 * yy, 0,
                                 ST_OK, 1'b1));
      end
      default: ;
    endcase
  endtask

  assign pending = exp_q.size();

  always @(posedge clk) begin
    qau_out_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy) predict_item(req);
      if (done) begin
        if (exp_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h", rsp);
        end else begin
          want = exp_q.pop_front();
          if (rsp !== want) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch: expected %h got %h", want, rsp);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/quaternion_arithmetic_unit_tb.sv */
`timescale 1ns / 100ps

module quaternion_arithmetic_unit_tb;
  import qau_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     done;
  qau_in_t  req;
  qau_out_t rsp;
  int       errors;
  int       pending;
  int       idle_cycles;

  quaternion_arithmetic_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
  );

  quaternion_arithmetic_unit_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_word(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< 8;
      5: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
      default: return $urandom;
    endcase
  endfunction

  function automatic qau_in_t rand_item(int sel);
    qau_in_t it;
    int m;
    m = (sel < 0) ? $urandom_range(0, 9) : sel;
    it.action = ($urandom_range(0, 30) == 0) ? ACT_NOP : 3'($urandom_range(0, 6));
    it.a_x = pick_word(m); it.a_y = pick_word(m); it.a_z = pick_word(m); it.a_w = pick_word(m);
    it.b_x = pick_word(m); it.b_y = pick_word(m); it.b_z = pick_word(m); it.b_w = pick_word(m);
    it.factor = ($urandom_range(0, 12) == 0) ? 32'd0 : pick_word(m);
    return it;
  endfunction

  task automatic send_item(qau_in_t it);
    start <= 1'b1;
    req <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("quaternion_arithmetic_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    qau_in_t it;
    int gap;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int act = 0; act < 8; act++) begin
      for (int m = 0; m < 3; m++) begin
        it = rand_item(m);
        it.action = 3'(act);
        if (m == 2) it.factor = 32'd0;
        send_item(it);
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 470;) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      for (int k = $urandom_range(1, 20); k > 0 && i < 470; k--) begin
        send_item(rand_item(-1));
        i++;
      end
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (i > 200 && i < 230) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("quaternion_arithmetic_unit_tb: done, clean");
    else $display("quaternion_arithmetic_unit_tb: done, errors");
    $finish;
  end

endmodule
